### rtl/pid_controller_inc_pos_defines.svh
// Assertion macros shared by the PID controller checker.
// Needs nothing else; include by bare file name.
`ifndef PID_CONTROLLER_INC_POS_DEFINES_SVH
`define PID_CONTROLLER_INC_POS_DEFINES_SVH

// Same-cycle implication under the block's asynchronous reset
`define PIDC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under the block's asynchronous reset
`define PIDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/pidc_pkg.sv
// Package for the PID controller: widths, saturation limits, register indexes.
// No dependencies; used by the top level and its checker.
`default_nettype none

package pidc_pkg;

	// Fixed-point and datapath widths
	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int ERR_W     = DATA_W + 1;
	localparam int OPD_W     = DATA_W + 3;
	localparam int ISUM_W    = 48;
	localparam int ISPLIT    = 24;
	localparam int PROD_W    = OPD_W + DATA_W;
	localparam int PRODL_W   = ISPLIT + 1 + DATA_W;
	localparam int PRODH_W   = (ISUM_W - ISPLIT) + DATA_W;
	localparam int PRODI_W   = ISUM_W + DATA_W;
	localparam int PD_W      = PROD_W + 1;
	localparam int ACC_W     = PRODI_W + 2;
	localparam int CFG_IDX_W = 3;

	// Saturation limits
	localparam logic signed [ISUM_W-1:0] ISUM_MAX = {1'b0, {(ISUM_W-1){1'b1}}};
	localparam logic signed [ISUM_W-1:0] ISUM_MIN = {1'b1, {(ISUM_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] DRIVE_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] DRIVE_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE         = 3'd0,
		CFG_GAIN_P       = 3'd1,
		CFG_GAIN_I       = 3'd2,
		CFG_GAIN_D       = 3'd3,
		CFG_INTEGRAL_MIN = 3'd4,
		CFG_INTEGRAL_MAX = 3'd5,
		CFG_DRIVE_MIN    = 3'd6,
		CFG_DRIVE_MAX    = 3'd7
	} cfg_idx_t;

	// Controller form
	typedef enum logic {
		MODE_INC = 1'b0,
		MODE_POS = 1'b1
	} pid_mode_t;

endpackage

`default_nettype wire

### rtl/pid_controller_inc_pos.sv
// PID controller, positional and incremental forms, signed Q16.16.
// Depends on pidc_pkg.
//
// Usage:
//   Slave stream carries one control tick per word: measured and setpoint.
//   Master stream returns one word per tick: the clamped drive.
//   The user must write configuration registers (mode, gains, clamp bounds)
//   by cfg_wr_en/cfg_index/cfg_wdata only with no tick in flight (unenforced).
// Timing:
//   Six register stages: input, error/integral update, multiply, product
//   merge, term sum, output. An accepted word passes through them in that
//   order to m_axis_tvalid. One word per cycle is sustained while the output
//   is not stalled; the drive feedback add, saturate and clamp in the output
//   stage close the loop through the held drive register.
// Reset:
//   arst_n clears the valid bits, configuration, error history, integral
//   and drive to zero; the datapath stage registers are not reset.
// Stall:
//   Each stage holds while the next one is full and stalled; bubbles close
//   up, so s_axis_tready stays high while any stage is free.
`default_nettype none

module pid_controller_inc_pos (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_wr_en,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,   // [31:0] measured, [63:32] setpoint
	// output stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata    // [31:0] drive
);

	localparam int DW = pidc_pkg::DATA_W;

	// Configuration registers
	pidc_pkg::pid_mode_t    mode_q;
	logic signed [DW-1:0]   gain_p_q, gain_i_q, gain_d_q;
	logic signed [DW-1:0]   int_min_q, int_max_q, drv_min_q, drv_max_q;

	// Handshake chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_valid_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_out;

	// Stage registers
	logic signed [DW-1:0]                   meas_s1, setp_s1;
	logic signed [pidc_pkg::OPD_W-1:0]      op_p_s2, op_d_s2;
	logic signed [pidc_pkg::ISUM_W-1:0]     op_i_s2;
	logic signed [pidc_pkg::PROD_W-1:0]     prod_p_s3, prod_d_s3;
	logic signed [pidc_pkg::PRODL_W-1:0]    prod_il_s3;
	logic signed [pidc_pkg::PRODH_W-1:0]    prod_ih_s3;
	logic signed [pidc_pkg::PD_W-1:0]       pd_s4;
	logic signed [pidc_pkg::PRODI_W-1:0]    prod_i_s4;
	logic signed [pidc_pkg::ACC_W-1:0]      sum_s5;
	logic signed [DW-1:0]                   drive_q;

	// Controller state; the error two ticks back is err_prev_q before the shift
	logic signed [pidc_pkg::ERR_W-1:0]  err_now_q, err_prev_q;
	logic signed [pidc_pkg::ISUM_W-1:0] isum_q;

	// Stage 2 combinational values
	logic signed [pidc_pkg::ERR_W-1:0]  err_new;
	logic signed [pidc_pkg::ISUM_W:0]   isum_add;
	logic signed [pidc_pkg::ISUM_W-1:0] isum_sat, isum_clamp, imin_ext, imax_ext;
	logic signed [pidc_pkg::OPD_W-1:0]  diff1, diff2;
	logic signed [pidc_pkg::OPD_W-1:0]  op_p_nxt, op_d_nxt;
	logic signed [pidc_pkg::ISUM_W-1:0] op_i_nxt;

	// Stage 3 operand split of the integral operand
	logic signed [pidc_pkg::ISPLIT:0]                 op_i_lo;
	logic signed [pidc_pkg::ISUM_W-pidc_pkg::ISPLIT-1:0] op_i_hi;

	// Output stage combinational values
	logic signed [pidc_pkg::ACC_W-1:0] acc;
	logic signed [DW-1:0]              drv_sat, drv_clamp;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= pidc_pkg::MODE_INC;
			gain_p_q  <= '0;
			gain_i_q  <= '0;
			gain_d_q  <= '0;
			int_min_q <= '0;
			int_max_q <= '0;
			drv_min_q <= '0;
			drv_max_q <= '0;
		end else if (cfg_wr_en) begin
			case (pidc_pkg::cfg_idx_t'(cfg_index))
				pidc_pkg::CFG_MODE:         mode_q    <= pidc_pkg::pid_mode_t'(cfg_wdata[0]);
				pidc_pkg::CFG_GAIN_P:       gain_p_q  <= cfg_wdata;
				pidc_pkg::CFG_GAIN_I:       gain_i_q  <= cfg_wdata;
				pidc_pkg::CFG_GAIN_D:       gain_d_q  <= cfg_wdata;
				pidc_pkg::CFG_INTEGRAL_MIN: int_min_q <= cfg_wdata;
				pidc_pkg::CFG_INTEGRAL_MAX: int_max_q <= cfg_wdata;
				pidc_pkg::CFG_DRIVE_MIN:    drv_min_q <= cfg_wdata;
				pidc_pkg::CFG_DRIVE_MAX:    drv_max_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Each stage loads when it is empty or its content moves on
	assign rdy_out       = !out_valid_q || m_axis_tready;
	assign rdy_s5        = !v_s5 || rdy_out;
	assign rdy_s4        = !v_s4 || rdy_s5;
	assign rdy_s3        = !v_s3 || rdy_s4;
	assign rdy_s2        = !v_s2 || rdy_s3;
	assign rdy_s1        = !v_s1 || rdy_s2;
	assign s_axis_tready = rdy_s1;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1)  v_s1        <= s_axis_tvalid;
			if (rdy_s2)  v_s2        <= v_s1;
			if (rdy_s3)  v_s3        <= v_s2;
			if (rdy_s4)  v_s4        <= v_s3;
			if (rdy_s5)  v_s5        <= v_s4;
			if (rdy_out) out_valid_q <= v_s5;
		end
	end

	// Stage 1: capture the input word
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && rdy_s1) begin
			meas_s1 <= s_axis_tdata[DW-1:0];
			setp_s1 <= s_axis_tdata[2*DW-1:DW];
		end
	end

	// Stage 2: error, integral update and multiplier operands
	always_comb begin
		err_new  = {setp_s1[DW-1], setp_s1} - {meas_s1[DW-1], meas_s1};

		// saturate the running sum to its register width
		isum_add = {isum_q[pidc_pkg::ISUM_W-1], isum_q}
			+ {{(pidc_pkg::ISUM_W-pidc_pkg::ERR_W+1){err_new[pidc_pkg::ERR_W-1]}}, err_new};
		if (isum_add[pidc_pkg::ISUM_W] != isum_add[pidc_pkg::ISUM_W-1])
			isum_sat = isum_add[pidc_pkg::ISUM_W] ? pidc_pkg::ISUM_MIN : pidc_pkg::ISUM_MAX;
		else
			isum_sat = isum_add[pidc_pkg::ISUM_W-1:0];

		// clamp the sum; equal bounds switch the clamp off
		imin_ext   = {{(pidc_pkg::ISUM_W-DW){int_min_q[DW-1]}}, int_min_q};
		imax_ext   = {{(pidc_pkg::ISUM_W-DW){int_max_q[DW-1]}}, int_max_q};
		isum_clamp = isum_sat;
		if (imin_ext != imax_ext) begin
			if (isum_clamp < imin_ext) isum_clamp = imin_ext;
			if (isum_clamp > imax_ext) isum_clamp = imax_ext;
		end

		// first and second differences of the error history
		diff1 = {{2{err_new[pidc_pkg::ERR_W-1]}}, err_new}
			- {{2{err_now_q[pidc_pkg::ERR_W-1]}}, err_now_q};
		diff2 = diff1
			- {{2{err_now_q[pidc_pkg::ERR_W-1]}}, err_now_q}
			+ {{2{err_prev_q[pidc_pkg::ERR_W-1]}}, err_prev_q};

		if (mode_q == pidc_pkg::MODE_POS) begin
			op_p_nxt = {{2{err_new[pidc_pkg::ERR_W-1]}}, err_new};
			op_i_nxt = isum_clamp;
			op_d_nxt = diff1;
		end else begin
			op_p_nxt = diff1;
			op_i_nxt = {{(pidc_pkg::ISUM_W-pidc_pkg::ERR_W){err_new[pidc_pkg::ERR_W-1]}},
				err_new};
			op_d_nxt = diff2;
		end
	end

	// Stage 2: shift the error history and, in positional form, store the integral
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_now_q   <= '0;
			err_prev_q  <= '0;
			isum_q      <= '0;
		end else if (v_s1 && rdy_s2) begin
			err_now_q  <= err_new;
			err_prev_q <= err_now_q;
			if (mode_q == pidc_pkg::MODE_POS)
				isum_q <= isum_clamp;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			op_p_s2 <= op_p_nxt;
			op_i_s2 <= op_i_nxt;
			op_d_s2 <= op_d_nxt;
		end
	end

	// Stage 3: multiply; the wide integral operand is split in two halves
	assign op_i_lo = {1'b0, op_i_s2[pidc_pkg::ISPLIT-1:0]};
	assign op_i_hi = op_i_s2[pidc_pkg::ISUM_W-1:pidc_pkg::ISPLIT];

	always_ff @(posedge clk) begin
		if (v_s2 && rdy_s3) begin
			prod_p_s3  <= gain_p_q * op_p_s2;
			prod_d_s3  <= gain_d_q * op_d_s2;
			prod_il_s3 <= gain_i_q * op_i_lo;
			prod_ih_s3 <= gain_i_q * op_i_hi;
		end
	end

	// Stage 4: merge integral halves, scale and add the P and D terms
	always_ff @(posedge clk) begin
		if (v_s3 && rdy_s4) begin
			prod_i_s4 <= (pidc_pkg::PRODI_W'(prod_ih_s3) <<< pidc_pkg::ISPLIT)
				+ pidc_pkg::PRODI_W'(prod_il_s3);
			pd_s4     <= pidc_pkg::PD_W'(prod_p_s3 >>> pidc_pkg::FRAC_BITS)
				+ pidc_pkg::PD_W'(prod_d_s3 >>> pidc_pkg::FRAC_BITS);
		end
	end

	// Stage 5: add the scaled I term
	always_ff @(posedge clk) begin
		if (v_s4 && rdy_s5)
			sum_s5 <= pidc_pkg::ACC_W'(pd_s4)
				+ pidc_pkg::ACC_W'(prod_i_s4 >>> pidc_pkg::FRAC_BITS);
	end

	// Output stage: add the held drive in incremental form, saturate, clamp
	always_comb begin
		if (mode_q == pidc_pkg::MODE_INC)
			acc = sum_s5 + pidc_pkg::ACC_W'(drive_q);
		else
			acc = sum_s5;

		if ((&acc[pidc_pkg::ACC_W-1:DW-1]) || !(|acc[pidc_pkg::ACC_W-1:DW-1]))
			drv_sat = acc[DW-1:0];
		else
			drv_sat = acc[pidc_pkg::ACC_W-1] ? pidc_pkg::DRIVE_MIN : pidc_pkg::DRIVE_MAX;

		drv_clamp = drv_sat;
		if (drv_min_q != drv_max_q) begin
			if (drv_clamp < drv_min_q) drv_clamp = drv_min_q;
			if (drv_clamp > drv_max_q) drv_clamp = drv_max_q;
		end
	end

	// Hold the drive; it is both the result word and the loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			drive_q <= '0;
		else if (v_s5 && rdy_out)
			drive_q <= drv_clamp;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = drive_q;

endmodule

`default_nettype wire

### rtl/pidc_checker.sv
// Port-level checker for the PID controller, bound to the top level.
// Depends on pidc_pkg and pid_controller_inc_pos_defines.svh.
`default_nettype none

`include "pid_controller_inc_pos_defines.svh"

module pidc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cfg_wr_en,
	input wire logic [2:0]  cfg_index,
	input wire logic [31:0] cfg_wdata,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata    // [31:0] drive
);

	logic signed [pidc_pkg::DATA_W-1:0] dmin_q, dmax_q, out_word;
	logic [2:0] inflight_q;
	logic       in_acc, out_acc, clamp_on, clamp_inv;

	assign in_acc      = s_axis_tvalid && s_axis_tready;
	assign out_acc     = m_axis_tvalid && m_axis_tready;
	assign out_word    = m_axis_tdata;
	assign clamp_on    = dmin_q < dmax_q;
	assign clamp_inv   = dmin_q > dmax_q;

	// Shadow the drive bounds from the write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dmin_q <= '0;
			dmax_q <= '0;
		end else if (cfg_wr_en) begin
			if (cfg_index == pidc_pkg::CFG_DRIVE_MIN) dmin_q <= cfg_wdata;
			if (cfg_index == pidc_pkg::CFG_DRIVE_MAX) dmax_q <= cfg_wdata;
		end
	end

	// Count words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inflight_q <= '0;
		else if (in_acc && !out_acc)
			inflight_q <= inflight_q + 3'd1;
		else if (!in_acc && out_acc)
			inflight_q <= inflight_q - 3'd1;
	end

	`PIDC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "drive word changed or dropped while stalled")
	`PIDC_ASSERT_IMPLY(a_in_ready, clk, arst_n, !m_axis_tvalid || m_axis_tready, s_axis_tready, "input stalled while output side is free")
	`PIDC_ASSERT_IMPLY(a_no_phantom, clk, arst_n, m_axis_tvalid, inflight_q != 3'd0, "drive word without an accepted tick")
	`PIDC_ASSERT_IMPLY(a_drive_range, clk, arst_n, m_axis_tvalid && clamp_on, out_word >= dmin_q && out_word <= dmax_q, "drive outside its clamp range")
	`PIDC_ASSERT_IMPLY(a_drive_inv, clk, arst_n, m_axis_tvalid && clamp_inv, out_word == dmax_q, "inverted clamp must give the upper bound")

endmodule

bind pid_controller_inc_pos pidc_checker u_pidc_checker (.*);

`default_nettype wire
